// ===== hw/rtl/wvda_pkg.sv =====
`default_nettype none

package wvda_pkg;

    // Field widths fixed by the item format
    localparam int OP_W       = 2;
    localparam int ENTRY_W    = 6;
    localparam int INDEX_W    = 10;
    localparam int COMP_W     = 16;
    localparam int WEIGHT_W   = 16;
    localparam int PROD_W     = COMP_W + WEIGHT_W;
    localparam int WEIGHT_FRAC = 12;
    localparam int SUM_W      = INDEX_W + 1;
    localparam int AXES       = 3;

    // Default sizes
    localparam int VERTEX_DEPTH_DEF = 1024;
    localparam int MAX_ENTRIES_DEF  = 64;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_APPLY = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    // Controller -> datapath
    typedef struct packed {
        logic capture;
        logic calc_quot;
        logic calc_addr;
        logic mem_write_base;
        logic mem_read;
        logic mem_write_upd;
        logic clear_flags;
        logic load_out;
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        op_t  op;
        logic apply_en;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wvda_ctrl.sv =====
`default_nettype none

module wvda_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire wvda_pkg::status_t stat,
    output wvda_pkg::cmd_t        cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_QUOT   = 6'b000010,
        ST_ADDR   = 6'b000100,
        ST_ACCESS = 6'b001000,
        ST_UPDATE = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_QUOT;
                end
            end
            ST_QUOT: begin
                cmd.calc_quot = 1'b1;
                state_next    = ST_ADDR;
            end
            ST_ADDR: begin
                cmd.calc_addr = 1'b1;
                state_next    = ST_ACCESS;
            end
            ST_ACCESS: begin
                case (stat.op)
                    wvda_pkg::OP_LOAD: begin
                        cmd.mem_write_base = 1'b1;
                        state_next         = ST_IDLE;
                    end
                    wvda_pkg::OP_APPLY: begin
                        if (stat.apply_en) begin
                            cmd.mem_read = 1'b1;
                            state_next   = ST_UPDATE;
                        end else begin
                            state_next   = ST_IDLE;
                        end
                    end
                    wvda_pkg::OP_READ: begin
                        cmd.mem_read = 1'b1;
                        state_next   = ST_RESULT;
                    end
                    default: begin
                        cmd.clear_flags = 1'b1;
                        state_next      = ST_IDLE;
                    end
                endcase
            end
            ST_UPDATE: begin
                cmd.mem_write_upd = 1'b1;
                state_next        = ST_IDLE;
            end
            ST_RESULT: begin
                // hold until the output register frees up
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/wvda_datapath.sv =====
`default_nettype none

module wvda_datapath #(
    parameter int VERTEX_DEPTH = wvda_pkg::VERTEX_DEPTH_DEF,
    parameter int MAX_ENTRIES  = wvda_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire wvda_pkg::cmd_t                      cmd,
    output wvda_pkg::status_t                        stat,
    input  wire logic [wvda_pkg::OP_W-1:0]           s_op,
    input  wire logic [wvda_pkg::ENTRY_W-1:0]        s_mesh_entry,
    input  wire logic [wvda_pkg::INDEX_W-1:0]        s_entry_base,
    input  wire logic [wvda_pkg::INDEX_W-1:0]        s_vertex_offset,
    input  wire logic signed [wvda_pkg::COMP_W-1:0]  s_comp_x,
    input  wire logic signed [wvda_pkg::COMP_W-1:0]  s_comp_y,
    input  wire logic signed [wvda_pkg::COMP_W-1:0]  s_comp_z,
    input  wire logic signed [wvda_pkg::WEIGHT_W-1:0] s_weight,
    input  wire logic                                s_weight_active,
    input  wire logic                                s_entry_active,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic                                cfg_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [wvda_pkg::COMP_W-1:0]       m_vertex_x,
    output logic signed [wvda_pkg::COMP_W-1:0]       m_vertex_y,
    output logic signed [wvda_pkg::COMP_W-1:0]       m_vertex_z,
    output logic                                     m_entry_touched
);

    localparam int SUM_W   = wvda_pkg::SUM_W;
    localparam int COMP_W  = wvda_pkg::COMP_W;
    localparam int PROD_W  = wvda_pkg::PROD_W;
    localparam int AXES    = wvda_pkg::AXES;
    localparam int AW      = $clog2(VERTEX_DEPTH);
    localparam int FLAG_N  = (MAX_ENTRIES < (2 ** wvda_pkg::ENTRY_W)) ?
                             MAX_ENTRIES : (2 ** wvda_pkg::ENTRY_W);

    // Exact floor(sum / VERTEX_DEPTH) over all sums: multiply by a rounded-up
    // reciprocal with 2^SHIFT >= VERTEX_DEPTH * 2^SUM_W.
    localparam int SHIFT   = SUM_W + $clog2(VERTEX_DEPTH);
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + 64'(VERTEX_DEPTH) - 64'd1) / 64'(VERTEX_DEPTH);
    localparam int RECIP_W = SUM_W + 2;
    localparam logic [RECIP_W-1:0] RECIP_C  = RECIP_W'(RECIP);
    localparam logic [SUM_W-1:0]   DEPTH_LO = SUM_W'(VERTEX_DEPTH);
    localparam logic signed [PROD_W-1:0] TRUNC_BIAS =
        PROD_W'((1 << wvda_pkg::WEIGHT_FRAC) - 1);

    // Captured item
    wvda_pkg::op_t                   op_reg;
    logic [wvda_pkg::ENTRY_W-1:0]    entry_reg;
    logic [SUM_W-1:0]                sum_reg;
    logic signed [COMP_W-1:0]        comp_reg [AXES];
    logic signed [wvda_pkg::WEIGHT_W-1:0] weight_reg;
    logic                            w_act_reg;
    logic                            e_act_reg;

    // Address reduction and products
    logic [SUM_W+RECIP_W-1:0]        quot_prod;
    logic [SUM_W-1:0]                quot_reg;
    logic [SUM_W-1:0]                rem_full;
    logic [AW-1:0]                   addr_reg;
    logic signed [PROD_W-1:0]        prod_reg [AXES];

    // Store and update
    logic [AXES*COMP_W-1:0]          mem [VERTEX_DEPTH];
    logic [AXES*COMP_W-1:0]          rd_word_reg;
    logic signed [PROD_W-1:0]        biased [AXES];
    logic [COMP_W-1:0]               upd [AXES];

    // Control state
    logic [FLAG_N-1:0]               flags_reg;
    logic [FLAG_N-1:0]               flags_next;
    logic [FLAG_N-1:0]               flags_shift;
    logic                            entry_ok;
    logic                            morph_enable_reg;
    logic                            m_valid_reg;

    logic signed [COMP_W-1:0]        vx_reg;
    logic signed [COMP_W-1:0]        vy_reg;
    logic signed [COMP_W-1:0]        vz_reg;
    logic                            touched_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg      <= wvda_pkg::op_t'(s_op);
            entry_reg   <= s_mesh_entry;
            sum_reg     <= SUM_W'(s_entry_base) + SUM_W'(s_vertex_offset);
            comp_reg[0] <= s_comp_x;
            comp_reg[1] <= s_comp_y;
            comp_reg[2] <= s_comp_z;
            weight_reg  <= s_weight;
            w_act_reg   <= s_weight_active;
            e_act_reg   <= s_entry_active;
        end
    end

    assign quot_prod = (SUM_W+RECIP_W)'(sum_reg) * (SUM_W+RECIP_W)'(RECIP_C);
    assign rem_full  = sum_reg - SUM_W'(quot_reg * DEPTH_LO);

    always_ff @(posedge aclk) begin
        if (cmd.calc_quot) begin
            quot_reg <= SUM_W'(quot_prod >> SHIFT);
            for (int i = 0; i < AXES; i++) begin
                prod_reg[i] <= weight_reg * comp_reg[i];
            end
        end
        if (cmd.calc_addr) begin
            addr_reg <= AW'(rem_full);
        end
    end

    // Truncate toward zero: bias negative products before the arithmetic shift
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            biased[i] = prod_reg[i] + (prod_reg[i][PROD_W-1] ? TRUNC_BIAS : '0);
            upd[i]    = rd_word_reg[i*COMP_W +: COMP_W] +
                        COMP_W'(biased[i] >>> wvda_pkg::WEIGHT_FRAC);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_write_base) begin
            mem[addr_reg] <= {comp_reg[2], comp_reg[1], comp_reg[0]};
        end else if (cmd.mem_write_upd) begin
            mem[addr_reg] <= {upd[2], upd[1], upd[0]};
        end
        if (cmd.mem_read) begin
            rd_word_reg <= mem[addr_reg];
        end
    end

    assign entry_ok    = (int'(entry_reg) < MAX_ENTRIES);
    assign flags_shift = flags_reg >> entry_reg;

    always_comb begin
        flags_next = flags_reg;
        if (cmd.clear_flags) begin
            flags_next = '0;
        end else if (cmd.mem_write_upd && entry_ok) begin
            flags_next = flags_reg | (FLAG_N'(1) << entry_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg        <= '0;
            morph_enable_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            flags_reg <= flags_next;
            if (cfg_valid) begin
                morph_enable_reg <= cfg_data;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            vx_reg      <= rd_word_reg[0*COMP_W +: COMP_W];
            vy_reg      <= rd_word_reg[1*COMP_W +: COMP_W];
            vz_reg      <= rd_word_reg[2*COMP_W +: COMP_W];
            touched_reg <= entry_ok && flags_shift[0];
        end
    end

    assign cfg_ready       = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_vertex_x      = vx_reg;
    assign m_vertex_y      = vy_reg;
    assign m_vertex_z      = vz_reg;
    assign m_entry_touched = touched_reg;

    assign stat.op       = op_reg;
    assign stat.apply_en = morph_enable_reg && e_act_reg && w_act_reg;
    assign stat.out_free = !m_valid_reg || m_ready;

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_flags |=> (flags_reg == '0))
        else $error("touched flags not cleared");

    a_update_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_write_upd |-> ($past(cmd.mem_read) && op_reg == wvda_pkg::OP_APPLY))
        else $error("delta write without a preceding store read");

    a_out_only_read: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (op_reg == wvda_pkg::OP_READ))
        else $error("result loaded for a non-read item");

    a_base_only_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_write_base |-> (op_reg == wvda_pkg::OP_LOAD && !cmd.mem_write_upd))
        else $error("base write for a non-load item");

endmodule

`default_nettype wire

// ===== hw/rtl/weighted_vertex_delta_accumulator.sv =====
`default_nettype none

// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      op, mesh_entry, entry_base, vertex_offset,
//                                             comp_x/y/z, weight, weight_active, entry_active
// m_        out        m_valid / m_ready      vertex_x/y/z, entry_touched
// cfg_      in         cfg_valid / cfg_ready  morph_enable (cfg_data)
//
// Every item passes the capture, quotient, address and access steps; an applied delta
// adds an update step and a read a result step, held while the previous result still
// waits in the output register. The steps come from the address reduction (reciprocal
// multiply, then remainder) and the read-modify-write over the single-port vertex store.
// Synchronous active-low reset clears the controller, the touched flags, the enable
// register and the output valid at once; the vertex store needs no clearing pass.
// A stall on m_ready holds the result register; the next item is still taken, and
// only a read stalls until the register frees.

module weighted_vertex_delta_accumulator #(
    parameter int VERTEX_DEPTH = wvda_pkg::VERTEX_DEPTH_DEF,
    parameter int MAX_ENTRIES  = wvda_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,

    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [wvda_pkg::OP_W-1:0]            s_op,
    input  wire logic [wvda_pkg::ENTRY_W-1:0]         s_mesh_entry,
    input  wire logic [wvda_pkg::INDEX_W-1:0]         s_entry_base,
    input  wire logic [wvda_pkg::INDEX_W-1:0]         s_vertex_offset,
    input  wire logic signed [wvda_pkg::COMP_W-1:0]   s_comp_x,
    input  wire logic signed [wvda_pkg::COMP_W-1:0]   s_comp_y,
    input  wire logic signed [wvda_pkg::COMP_W-1:0]   s_comp_z,
    input  wire logic signed [wvda_pkg::WEIGHT_W-1:0] s_weight,
    input  wire logic                                 s_weight_active,
    input  wire logic                                 s_entry_active,

    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic                                 cfg_data,

    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [wvda_pkg::COMP_W-1:0]        m_vertex_x,
    output logic signed [wvda_pkg::COMP_W-1:0]        m_vertex_y,
    output logic signed [wvda_pkg::COMP_W-1:0]        m_vertex_z,
    output logic                                      m_entry_touched
);

    // Command and status between sequencer and datapath
    wvda_pkg::cmd_t    cmd;
    wvda_pkg::status_t stat;

    // Sequencer: advance one transaction at a time through the steps
    wvda_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath: vertex store, blend arithmetic, touched flags, result register
    wvda_datapath #(
        .VERTEX_DEPTH (VERTEX_DEPTH),
        .MAX_ENTRIES  (MAX_ENTRIES)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_op            (s_op),
        .s_mesh_entry    (s_mesh_entry),
        .s_entry_base    (s_entry_base),
        .s_vertex_offset (s_vertex_offset),
        .s_comp_x        (s_comp_x),
        .s_comp_y        (s_comp_y),
        .s_comp_z        (s_comp_z),
        .s_weight        (s_weight),
        .s_weight_active (s_weight_active),
        .s_entry_active  (s_entry_active),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_vertex_x      (m_vertex_x),
        .m_vertex_y      (m_vertex_y),
        .m_vertex_z      (m_vertex_z),
        .m_entry_touched (m_entry_touched)
    );

endmodule

`default_nettype wire

// ===== tb/tb_weighted_vertex_delta_accumulator.sv =====
`timescale 1ns / 100ps

module tb_weighted_vertex_delta_accumulator;
    import wvda_pkg::*;

    localparam int DEPTH         = VERTEX_DEPTH_DEF;
    localparam int ENTRIES       = MAX_ENTRIES_DEF;
    localparam int IDLE_PCT      = 14;
    // Longest item is a read plus a held output register; leave margin
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 2000;

    // One transaction on the input channel
    typedef struct {
        op_t                        op;
        logic [ENTRY_W-1:0]         entry;
        logic [INDEX_W-1:0]         base;
        logic [INDEX_W-1:0]         offs;
        logic signed [COMP_W-1:0]   cx;
        logic signed [COMP_W-1:0]   cy;
        logic signed [COMP_W-1:0]   cz;
        logic signed [WEIGHT_W-1:0] w;
        logic                       wact;
        logic                       eact;
    } vertex_op_t;

    // One transaction on the result channel
    typedef struct {
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] z;
        logic                     touched;
    } vertex_read_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                       s_valid         = 1'b0;
    logic                       s_ready;
    logic [OP_W-1:0]            s_op            = '0;
    logic [ENTRY_W-1:0]         s_mesh_entry    = '0;
    logic [INDEX_W-1:0]         s_entry_base    = '0;
    logic [INDEX_W-1:0]         s_vertex_offset = '0;
    logic signed [COMP_W-1:0]   s_comp_x        = '0;
    logic signed [COMP_W-1:0]   s_comp_y        = '0;
    logic signed [COMP_W-1:0]   s_comp_z        = '0;
    logic signed [WEIGHT_W-1:0] s_weight        = '0;
    logic                       s_weight_active = 1'b0;
    logic                       s_entry_active  = 1'b0;

    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_data  = 1'b0;

    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [COMP_W-1:0] m_vertex_x;
    logic signed [COMP_W-1:0] m_vertex_y;
    logic signed [COMP_W-1:0] m_vertex_z;
    logic                     m_entry_touched;

    // Shadow copy of the block state, advanced on every accepted transaction
    logic [COMP_W-1:0] mirror_x [DEPTH];
    logic [COMP_W-1:0] mirror_y [DEPTH];
    logic [COMP_W-1:0] mirror_z [DEPTH];
    logic              mirror_touched [ENTRIES];
    logic              mirror_enable = 1'b0;

    vertex_op_t   pending_ops[$];
    vertex_read_t expected_reads[$];
    vertex_op_t   presented;
    vertex_read_t want;

    // Stimulus bookkeeping: which addresses hold a loaded vertex
    bit          gen_loaded [DEPTH];
    int unsigned loaded_list[$];
    int unsigned hot_addr[$];

    bit calm = 1'b0;          // suppress all idling on both sides
    int mismatch_count = 0;
    int idle_cycles = 0;

    weighted_vertex_delta_accumulator uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_mesh_entry    (s_mesh_entry),
        .s_entry_base    (s_entry_base),
        .s_vertex_offset (s_vertex_offset),
        .s_comp_x        (s_comp_x),
        .s_comp_y        (s_comp_y),
        .s_comp_z        (s_comp_z),
        .s_weight        (s_weight),
        .s_weight_active (s_weight_active),
        .s_entry_active  (s_entry_active),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_vertex_x      (m_vertex_x),
        .m_vertex_y      (m_vertex_y),
        .m_vertex_z      (m_vertex_z),
        .m_entry_touched (m_entry_touched)
    );

    always #5 aclk = ~aclk;

    function automatic int unsigned vertex_addr(vertex_op_t it);
        return (int'(it.base) + int'(it.offs)) % DEPTH;
    endfunction

    // Scale the delta by the Q3.12 weight, truncate toward zero, add with 16-bit wrap
    function automatic logic [COMP_W-1:0] blend_axis(logic [COMP_W-1:0] cur,
                                                    logic signed [WEIGHT_W-1:0] w,
                                                    logic signed [COMP_W-1:0] d);
        int prod;
        int step;
        prod = int'(w) * int'(d);
        step = prod / (1 << WEIGHT_FRAC);
        return cur + step[COMP_W-1:0];
    endfunction

    // Advance the shadow state by one transaction; queue the result of a read
    function automatic void mirror_vertex_op(vertex_op_t it);
        int unsigned a;
        vertex_read_t r;
        a = vertex_addr(it);
        case (it.op)
            OP_LOAD: begin
                mirror_x[a] = it.cx;
                mirror_y[a] = it.cy;
                mirror_z[a] = it.cz;
            end
            OP_APPLY: begin
                if (mirror_enable && it.eact && it.wact) begin
                    mirror_x[a] = blend_axis(mirror_x[a], it.w, it.cx);
                    mirror_y[a] = blend_axis(mirror_y[a], it.w, it.cy);
                    mirror_z[a] = blend_axis(mirror_z[a], it.w, it.cz);
                    mirror_touched[it.entry] = 1'b1;
                end
            end
            OP_READ: begin
                r.x = mirror_x[a];
                r.y = mirror_y[a];
                r.z = mirror_z[a];
                r.touched = mirror_touched[it.entry];
                expected_reads.push_back(r);
            end
            default: begin
                foreach (mirror_touched[i]) mirror_touched[i] = 1'b0;
            end
        endcase
    endfunction

    function automatic vertex_op_t make_op(op_t op, int entry, int base, int offs,
                                           int x, int y, int z, int w,
                                           bit wa = 1'b1, bit ea = 1'b1);
        vertex_op_t it;
        it.op    = op;
        it.entry = ENTRY_W'(entry);
        it.base  = INDEX_W'(base);
        it.offs  = INDEX_W'(offs);
        it.cx    = COMP_W'(x);
        it.cy    = COMP_W'(y);
        it.cz    = COMP_W'(z);
        it.w     = WEIGHT_W'(w);
        it.wact  = wa;
        it.eact  = ea;
        return it;
    endfunction

    // Mix full-range values with small ones so sums neither always nor never wrap
    function automatic logic signed [COMP_W-1:0] random_comp();
        logic signed [COMP_W-1:0] v;
        v = COMP_W'($urandom);
        if ($urandom_range(1)) v = v >>> 6;
        return v;
    endfunction

    function automatic logic signed [WEIGHT_W-1:0] random_weight();
        logic signed [WEIGHT_W-1:0] w;
        case ($urandom_range(9))
            0: w = 16'sh8000;
            1: w = 16'sh7FFF;
            2: w = '0;
            3: w = 16'sh1000;
            4: w = -16'sh1000;
            default: w = WEIGHT_W'($urandom);
        endcase
        return w;
    endfunction

    // Loads go mostly into a small hot set, deltas and reads only to loaded vertices;
    // clears show up now and then to reset the touched flags
    function automatic vertex_op_t random_vertex_op();
        vertex_op_t it;
        int unsigned pick;
        int unsigned a;
        pick = $urandom_range(99);
        if (loaded_list.size() == 0 || pick < 22)
            it.op = OP_LOAD;
        else if (pick < 62)
            it.op = OP_APPLY;
        else if (pick < 94)
            it.op = OP_READ;
        else
            it.op = OP_CLEAR;
        if (it.op == OP_LOAD)
            a = ($urandom_range(99) < 80) ? hot_addr[$urandom_range(hot_addr.size() - 1)]
                                          : $urandom_range(DEPTH - 1);
        else
            a = loaded_list[$urandom_range(loaded_list.size() - 1)];
        it.base  = INDEX_W'($urandom_range(DEPTH - 1));
        it.offs  = INDEX_W'(a - it.base);
        it.entry = ENTRY_W'(($urandom_range(99) < 70) ? $urandom_range(7)
                                                       : $urandom_range(ENTRIES - 1));
        it.cx    = random_comp();
        it.cy    = random_comp();
        it.cz    = random_comp();
        it.w     = random_weight();
        it.wact  = ($urandom_range(99) < 85);
        it.eact  = ($urandom_range(99) < 85);
        return it;
    endfunction

    function automatic void enqueue_op(vertex_op_t it);
        int unsigned a;
        a = vertex_addr(it);
        if (it.op == OP_LOAD && !gen_loaded[a]) begin
            gen_loaded[a] = 1'b1;
            loaded_list.push_back(a);
        end
        pending_ops.push_back(it);
    endfunction

    function automatic void compare_field(string name, logic [COMP_W-1:0] exp_v,
                                          logic [COMP_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, $signed(exp_v), $signed(act_v));
            mismatch_count++;
        end
    endfunction

    // Hold until every queued transaction went in and every read came back
    task automatic wait_drained();
        while (pending_ops.size() != 0 || s_valid || expected_reads.size() != 0)
            @(posedge aclk);
    endtask

    // Drain, then let loads, deltas and clears in flight finish
    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_morph_enable(bit v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        mirror_enable = v;
    endtask

    // Driver: predict on acceptance, then present the next transaction or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                mirror_vertex_op(presented);
            if (!s_valid || s_ready) begin
                if (pending_ops.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    presented = pending_ops.pop_front();
                    s_valid         <= 1'b1;
                    s_op            <= presented.op;
                    s_mesh_entry    <= presented.entry;
                    s_entry_base    <= presented.base;
                    s_vertex_offset <= presented.offs;
                    s_comp_x        <= presented.cx;
                    s_comp_y        <= presented.cy;
                    s_comp_z        <= presented.cz;
                    s_weight        <= presented.w;
                    s_weight_active <= presented.wact;
                    s_entry_active  <= presented.eact;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each read result with the oldest prediction, stall at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_reads.size() == 0) begin
                    $display("%0t: result with none expected, actual x=%0d y=%0d z=%0d t=%0b",
                             $time, m_vertex_x, m_vertex_y, m_vertex_z, m_entry_touched);
                    mismatch_count++;
                end else begin
                    want = expected_reads.pop_front();
                    compare_field("vertex_x", want.x, m_vertex_x);
                    compare_field("vertex_y", want.y, m_vertex_y);
                    compare_field("vertex_z", want.z, m_vertex_z);
                    compare_field("entry_touched", COMP_W'(want.touched),
                                  COMP_W'(m_entry_touched));
                end
            end
            m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: end the run if no channel moves a transaction for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("tb_weighted_vertex_delta_accumulator: FAIL");
            $finish;
        end
    end

    initial begin
        foreach (mirror_touched[i]) mirror_touched[i] = 1'b0;
        repeat (24) hot_addr.push_back($urandom_range(DEPTH - 1));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, wrap of the address sum, truncation of the
        // scaled delta, back-to-back deltas on one vertex, suppressed deltas, clear
        write_morph_enable(1'b1);
        enqueue_op(make_op(OP_LOAD, 0, 0, 0, 32767, -32768, 0, 0));
        enqueue_op(make_op(OP_LOAD, 63, 1023, 1023, -1, 1, -32768, 32767));
        enqueue_op(make_op(OP_LOAD, 5, 1020, 9, 100, -100, 7, -32768));
        enqueue_op(make_op(OP_READ, 0, 0, 0, 0, 0, 0, 0));
        enqueue_op(make_op(OP_APPLY, 0, 0, 0, 32767, -32768, 1, 32767));
        enqueue_op(make_op(OP_APPLY, 0, 1000, 24, -32768, 32767, -1, -32768));
        enqueue_op(make_op(OP_READ, 0, 0, 0, 0, 0, 0, 0));
        enqueue_op(make_op(OP_APPLY, 63, 1023, 1023, 9, 9, 9, 4096, 1'b0, 1'b1));
        enqueue_op(make_op(OP_APPLY, 63, 1023, 1023, 9, 9, 9, 4096, 1'b1, 1'b0));
        enqueue_op(make_op(OP_READ, 63, 1023, 1023, 0, 0, 0, 0));
        enqueue_op(make_op(OP_APPLY, 63, 511, 511, -5, 5, 3, 4096));
        enqueue_op(make_op(OP_APPLY, 62, 1020, 9, 4095, -4095, 4096, 1));
        enqueue_op(make_op(OP_APPLY, 62, 5, 0, 4097, -4097, 1, -1));
        enqueue_op(make_op(OP_READ, 62, 1020, 9, 0, 0, 0, 0));
        enqueue_op(make_op(OP_READ, 63, 1022, 0, 0, 0, 0, 0));
        enqueue_op(make_op(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        enqueue_op(make_op(OP_READ, 0, 0, 0, 0, 0, 0, 0));
        enqueue_op(make_op(OP_READ, 63, 1022, 0, 0, 0, 0, 0));
        enqueue_op(make_op(OP_APPLY, 1, 5, 0, 1234, -1234, 77, 0));
        enqueue_op(make_op(OP_READ, 1, 5, 0, 0, 0, 0, 0));
        settle();

        // Global enable off: a fully enabled delta must leave vertex and flag alone
        write_morph_enable(1'b0);
        enqueue_op(make_op(OP_APPLY, 2, 0, 0, 500, 500, 500, 4096));
        enqueue_op(make_op(OP_READ, 2, 0, 0, 0, 0, 0, 0));
        repeat (150) enqueue_op(random_vertex_op());
        settle();

        // Full rate on both sides: no idling on the sender or on the result channel
        calm = 1'b1;
        write_morph_enable(1'b1);
        repeat (300) enqueue_op(random_vertex_op());
        settle();
        calm = 1'b0;

        // Pause the sender halfway until every read has come back
        write_morph_enable(1'b1);
        repeat (150) enqueue_op(random_vertex_op());
        wait_drained();
        repeat (150) enqueue_op(random_vertex_op());
        settle();

        write_morph_enable(1'b0);
        repeat (100) enqueue_op(random_vertex_op());
        settle();

        write_morph_enable(1'b1);
        repeat (150) enqueue_op(random_vertex_op());
        settle();

        if (mismatch_count == 0 && expected_reads.size() == 0)
            $display("tb_weighted_vertex_delta_accumulator: PASS");
        else
            $display("tb_weighted_vertex_delta_accumulator: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/wvda_pkg.sv
hw/rtl/wvda_ctrl.sv
hw/rtl/wvda_datapath.sv
hw/rtl/weighted_vertex_delta_accumulator.sv
tb/tb_weighted_vertex_delta_accumulator.sv
